>>> rtl/lsbf_pkg.sv
// Shared types, constants and frame builder for the LCD serial byte framer.
package lsbf_pkg;

  localparam int unsigned NumCells   = 24;
  localparam int unsigned BodyBits   = 16;
  localparam int unsigned HdrBits    = 8;
  localparam int unsigned HdrOnes    = 5;
  localparam logic [7:0]  NibbleHiMask = 8'hF0;

  typedef struct packed {
    logic vld;
    logic last;
    logic data_bit;
  } cell_t;

  typedef struct packed {
    logic load;
    logic advance;
  } cell_ctrl_t;

  typedef cell_t [NumCells-1:0] frame_t;

  // Cell 0 goes out first. Header (when sent) occupies cells 0..7.
  function automatic frame_t build_frame(input logic [7:0] byte_v,
                                         input logic       cmd,
                                         input logic       hdr);
    frame_t      f;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [15:0] body;
    int unsigned base;
    f    = '0;
    hi   = byte_v & NibbleHiMask;
    lo   = {byte_v[3:0], 4'b0000};
    body = {hi, lo};
    base = hdr ? HdrBits : 0;
    if (hdr) begin
      for (int unsigned k = 0; k < HdrBits; k++) begin
        f[k].vld  = 1'b1;
        f[k].last = 1'b0;
        f[k].data_bit = (k < HdrOnes) ? 1'b1 : ((k == HdrOnes + 1) ? ~cmd : 1'b0);
      end
    end
    for (int unsigned k = 0; k < BodyBits; k++) begin
      f[base + k].vld      = 1'b1;
      f[base + k].last     = (k == BodyBits - 1);
      f[base + k].data_bit = body[BodyBits - 1 - k];
    end
    return f;
  endfunction

endpackage

>>> rtl/lsbf_if.sv
// Valid/ready channel interfaces for input bytes and output serial bits.
interface lsbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       is_command;
  modport source (output valid, output payload_byte, output is_command, input ready);
  modport sink   (input valid, input payload_byte, input is_command, output ready);
endinterface

interface lsbf_out_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic last;
  modport source (output valid, output data_bit, output last, input ready);
  modport sink   (input valid, input data_bit, input last, output ready);
endinterface

>>> rtl/lsbf_cell.sv
// One shift cell of the serial bit chain: loads in parallel or takes its neighbor.
module lsbf_cell
  import lsbf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  cell_t      load_i,
  input  cell_t      next_i,
  output cell_t      cell_o
);

  cell_t cell_d, cell_q;

  always_comb begin
    cell_d = cell_q;
    if (ctrl_i.load) begin
      cell_d = load_i;
    end else if (ctrl_i.advance) begin
      cell_d = next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule

>>> rtl/lcd_serial_byte_framer.sv
// Top level of the LCD serial byte framer: frame builder and shift chain.
//
// Channel  Dir  Payload                     Item
// in_i     in   payload_byte[7:0], is_command  one byte to frame
// out_o    out  data_bit, last              one serial bit
//
// One output bit per cycle while the output is ready; a byte yields 24 bits
// (header) or 16 (repeat data byte), held in the 24-cell shift chain, which
// drains one cell per cycle unless the output stalls.
// A new byte is taken in the same cycle its predecessor's last bit leaves,
// so frames run back to back with no gap.
// Output stalls freeze the whole chain. Reset empties the chain and
// returns to command mode.
module lcd_serial_byte_framer
  import lsbf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  lsbf_in_if.sink    in_i,
  lsbf_out_if.source out_o
);

  frame_t     chain;      // current cell contents, cell 0 at the output
  frame_t     frame;      // parallel load value for a new byte
  cell_ctrl_t ctrl;
  logic       advance;
  logic       take;
  logic       send_hdr;
  logic       data_mode_d, data_mode_q;

  // Chain moves whenever the head is empty or being taken.
  assign advance = ~chain[0].vld | out_o.ready;

  // Valid cells are contiguous from cell 0, so an empty cell 1 means the
  // chain is empty after this shift.
  assign in_i.ready = advance & ~chain[1].vld;
  assign take       = in_i.valid & in_i.ready;

  // Commands always get a header; data only when leaving command mode.
  assign send_hdr = in_i.is_command | ~data_mode_q;
  assign frame    = build_frame(in_i.payload_byte, in_i.is_command, send_hdr);

  assign ctrl.load    = take;
  assign ctrl.advance = advance;

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    cell_t next_c;
    if (g == NumCells - 1) begin : g_tail
      assign next_c = '0;
    end else begin : g_mid
      assign next_c = chain[g + 1];
    end
    lsbf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .load_i (frame[g]),
      .next_i (next_c),
      .cell_o (chain[g])
    );
  end

  always_comb begin
    data_mode_d = data_mode_q;
    if (take) begin
      data_mode_d = ~in_i.is_command;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_mode_q <= 1'b0;
    end else begin
      data_mode_q <= data_mode_d;
    end
  end

  assign out_o.valid    = chain[0].vld;
  assign out_o.data_bit = chain[0].data_bit;
  assign out_o.last     = chain[0].last;

endmodule
